// ===== rtl/core/svpwm_pkg.sv =====
package svpwm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int VOLT_BITS_DEF  = 16;
    localparam int LIMIT_BITS     = 15;
    localparam int CORDIC_STEPS   = 24;
    localparam int VEC_PRE        = 6;
    localparam logic [14:0] LIMIT_RESET = 15'd16384;
    localparam logic signed [31:0] INVK_Q30  = 32'sd652032874;
    localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    // Arctangent of 2^-i as a fraction of a turn, scaled by 2^32.
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        case (i)
            0:  t = 32'd536870912;
            1:  t = 32'd316933406;
            2:  t = 32'd167458907;
            3:  t = 32'd85004756;
            4:  t = 32'd42667331;
            5:  t = 32'd21354465;
            6:  t = 32'd10679838;
            7:  t = 32'd5340245;
            8:  t = 32'd2670163;
            9:  t = 32'd1335087;
            10: t = 32'd667544;
            11: t = 32'd333772;
            12: t = 32'd166886;
            13: t = 32'd83443;
            14: t = 32'd41722;
            15: t = 32'd20861;
            16: t = 32'd10430;
            17: t = 32'd5215;
            18: t = 32'd2608;
            19: t = 32'd1304;
            20: t = 32'd652;
            21: t = 32'd326;
            22: t = 32'd163;
            23: t = 32'd81;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/core/space_vector_pwm_duty.sv =====
// Space-vector modulator: takes a q/d voltage command and an electrical angle and
// returns three saturated phase voltages and the sector number (1 to 6). The pipeline
// accepts one word per clock cycle unless the output stalls, and holds 59 register
// stages: 27 in the vectoring CORDIC (entry, 24 micro-rotations, gain correction and
// output), 2 sector-split stages, 25 rotation CORDIC stages (entry and 24 micro-rotations)
// and 5 mapping stages, the last of which is the output register.
// A stall on the output freezes the whole pipeline, so the input stalls in every cycle
// in which a finished output word waits, whether or not the stages behind it are full.
// The supply limit is written through i_cfg_we and i_cfg_data; the user must write it
// only while the block is idle, since the block itself does not enforce this.
module space_vector_pwm_duty #(
    parameter int ANGLE_BITS = svpwm_pkg::ANGLE_BITS_DEF,
    parameter int VOLT_BITS  = svpwm_pkg::VOLT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [svpwm_pkg::LIMIT_BITS-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [VOLT_BITS-1:0]    i_volt_q,
    input  logic signed [VOLT_BITS-1:0]    i_volt_d,
    input  logic [ANGLE_BITS-1:0]          i_elec_angle,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [VOLT_BITS-1:0]    o_phase_a,
    output logic signed [VOLT_BITS-1:0]    o_phase_b,
    output logic signed [VOLT_BITS-1:0]    o_phase_c,
    output logic [2:0]                     o_sector_num
);
    import svpwm_pkg::*;

    logic [LIMIT_BITS-1:0] r_limit;
    logic en;

    // The pipeline advances unless a finished word is held at the output.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    logic v1, v2;
    logic signed [VOLT_BITS+1:0] mag1, mag2;
    logic [31:0] theta1;
    logic [2:0] sidx2;
    logic signed [31:0] cos2, sin2;

    svpwm_vec_cordic #(.VOLT_BITS(VOLT_BITS), .ANGLE_BITS(ANGLE_BITS)) u_vec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_q(i_volt_q), .i_d(i_volt_d), .i_angle(i_elec_angle),
        .o_valid(v1), .o_mag(mag1), .o_theta(theta1)
    );

    svpwm_rot_cordic #(.VOLT_BITS(VOLT_BITS)) u_rot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v1),
        .i_mag(mag1), .i_theta(theta1),
        .o_valid(v2), .o_mag(mag2), .o_sidx(sidx2), .o_cos(cos2), .o_sin(sin2)
    );

    svpwm_phase_map #(.VOLT_BITS(VOLT_BITS)) u_map (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_limit(r_limit),
        .i_valid(v2), .i_mag(mag2), .i_sidx(sidx2), .i_cos(cos2), .i_sin(sin2),
        .o_valid(o_valid), .o_a(o_phase_a), .o_b(o_phase_b), .o_c(o_phase_c),
        .o_sector(o_sector_num)
    );

endmodule

// ===== rtl/core/svpwm_vec_cordic.sv =====
// Pipelined vectoring CORDIC: one micro-rotation per register stage.
module svpwm_vec_cordic #(
    parameter int VOLT_BITS  = svpwm_pkg::VOLT_BITS_DEF,
    parameter int ANGLE_BITS = svpwm_pkg::ANGLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [VOLT_BITS-1:0]   i_q,
    input  logic signed [VOLT_BITS-1:0]   i_d,
    input  logic [ANGLE_BITS-1:0]         i_angle,
    output logic                          o_valid,
    output logic signed [VOLT_BITS+1:0]   o_mag,
    output logic [31:0]                   o_theta
);
    import svpwm_pkg::*;

    localparam int N  = CORDIC_STEPS;
    // x grows by up to sqrt(2)*1.65; three guard bits over the pre-scaled input.
    localparam int XW = VOLT_BITS + VEC_PRE + 3;
    localparam int MW = VOLT_BITS + 2;

    logic                 r_v [0:N];
    logic                 r_dz [0:N];
    logic signed [XW-1:0] r_x [0:N];
    logic signed [XW-1:0] r_y [0:N];
    logic [31:0]          r_z [0:N];
    logic [31:0]          r_th [0:N];
    logic signed [MW-1:0] r_qm [0:N];

    logic signed [XW-1:0] n_x0, n_y0;

    // Entry stage: fold left half-plane onto the right.
    always_comb begin
        if (i_d < 0) begin
            n_x0 = -(XW'(i_d) <<< VEC_PRE);
            n_y0 = -(XW'(i_q) <<< VEC_PRE);
        end else begin
            n_x0 = XW'(i_d) <<< VEC_PRE;
            n_y0 = XW'(i_q) <<< VEC_PRE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_dz[0] <= (i_d == '0);
            r_x[0]  <= n_x0;
            r_y[0]  <= n_y0;
            r_z[0]  <= (i_d < 0) ? HALF_TURN : 32'd0;
            r_th[0] <= {i_angle, {(32-ANGLE_BITS){1'b0}}};
            r_qm[0] <= MW'(i_q);
        end
    end

    // Micro-rotation stages.
    for (genvar g = 0; g < N; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_dz[g+1] <= r_dz[g];
                r_th[g+1] <= r_th[g];
                r_qm[g+1] <= r_qm[g];
                if (r_y[g] > 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_turn(g);
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_turn(g);
                end
            end
        end
    end

    // Gain correction, then rounding and selection of the zero-d case.
    logic                       r_mv, r_mdz;
    logic signed [XW+32-1:0]    r_prod;
    logic [31:0]                r_mth, r_mz;
    logic signed [MW-1:0]       r_mq;
    logic signed [XW+32-1:0]    n_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (i_en) begin
            r_mv <= r_v[N];
        end
        if (i_en) begin
            r_prod <= (XW+32)'(r_x[N]) * (XW+32)'(INVK_Q30);
            r_mdz  <= r_dz[N];
            r_mth  <= r_th[N];
            r_mz   <= r_z[N];
            r_mq   <= r_qm[N];
        end
    end

    assign n_rnd = (r_prod + ((XW+32)'(1) <<< (29 + VEC_PRE))) >>> (30 + VEC_PRE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_mv;
        end
        if (i_en) begin
            o_mag   <= r_mdz ? r_mq : MW'(n_rnd);
            o_theta <= r_mth + (r_mdz ? QUARTER_TURN : r_mz);
        end
    end

endmodule

// ===== rtl/core/svpwm_rot_cordic.sv =====
// Sector split and pipelined rotation CORDIC giving cos and sin of the in-sector angle.
module svpwm_rot_cordic #(
    parameter int VOLT_BITS = svpwm_pkg::VOLT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [VOLT_BITS+1:0] i_mag,
    input  logic [31:0]                 i_theta,
    output logic                        o_valid,
    output logic signed [VOLT_BITS+1:0] o_mag,
    output logic [2:0]                  o_sidx,
    output logic signed [31:0]          o_cos,
    output logic signed [31:0]          o_sin
);
    import svpwm_pkg::*;

    localparam int N  = CORDIC_STEPS;
    localparam int MW = VOLT_BITS + 2;
    // Reciprocal of 6 for a 32-bit dividend: ceil(2^34/6).
    localparam logic [34:0] RECIP6 = 35'd2863311531;

    // Stage A: multiply by six.
    logic              r_av;
    logic [34:0]       r_t6;
    logic signed [MW-1:0] r_am;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (i_en) begin
            r_av <= i_valid;
        end
        if (i_en) begin
            r_t6 <= {3'b000, i_theta} * 35'd6;
            r_am <= i_mag;
        end
    end

    // Stage B: divide the low word by six through the reciprocal.
    logic              r_bv;
    logic [66:0]       r_bq;
    logic [2:0]        r_bs;
    logic signed [MW-1:0] r_bm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
        end else if (i_en) begin
            r_bv <= r_av;
        end
        if (i_en) begin
            r_bq <= {35'd0, r_t6[31:0]} * {32'd0, RECIP6};
            r_bs <= r_t6[34:32];
            r_bm <= r_am;
        end
    end

    logic                 r_v [0:N];
    logic signed [32:0]   r_x [0:N];
    logic signed [32:0]   r_y [0:N];
    logic signed [33:0]   r_z [0:N];
    logic [2:0]           r_s [0:N];
    logic signed [MW-1:0] r_m [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r_bv;
        end
        if (i_en) begin
            r_x[0] <= 33'(INVK_Q30);
            r_y[0] <= '0;
            r_z[0] <= {2'b00, r_bq[65:34]};
            r_s[0] <= r_bs;
            r_m[0] <= r_bm;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_s[g+1] <= r_s[g];
                r_m[g+1] <= r_m[g];
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - 34'(atan_turn(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + 34'(atan_turn(g));
                end
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_mag   = r_m[N];
    assign o_sidx  = r_s[N];
    assign o_cos   = 32'(r_x[N]);
    assign o_sin   = 32'(r_y[N]);

endmodule

// ===== rtl/core/svpwm_phase_map.sv =====
// Active times, zero time and per-sector phase mapping with saturation.
module svpwm_phase_map #(
    parameter int VOLT_BITS = svpwm_pkg::VOLT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [svpwm_pkg::LIMIT_BITS-1:0] i_limit,
    input  logic                        i_valid,
    input  logic signed [VOLT_BITS+1:0] i_mag,
    input  logic [2:0]                  i_sidx,
    input  logic signed [31:0]          i_cos,
    input  logic signed [31:0]          i_sin,
    output logic                        o_valid,
    output logic signed [VOLT_BITS-1:0] o_a,
    output logic signed [VOLT_BITS-1:0] o_b,
    output logic signed [VOLT_BITS-1:0] o_c,
    output logic [2:0]                  o_sector
);
    import svpwm_pkg::*;

    localparam int MW = VOLT_BITS + 2;
    localparam int TW = VOLT_BITS + 4;
    localparam int PW = MW + 34;
    localparam logic signed [TW+2:0] HI = (TW+3)'((64'sd1 <<< (VOLT_BITS-1)) - 1);
    localparam logic signed [TW+2:0] LO = -HI - 1;

    // Stage 1: k2 = sqrt3 * sin, and three times cos.
    logic r1_v;
    logic signed [63:0] r1_k2p;
    logic signed [33:0] r1_cos;
    logic [2:0] r1_s;
    logic signed [MW-1:0] r1_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
        if (i_en) begin
            r1_k2p <= 64'(i_sin) * 64'(SQRT3_Q30);
            r1_cos <= 34'(i_cos) * 34'sd3;
            r1_s   <= i_sidx;
            r1_m   <= i_mag;
        end
    end

    // Stage 2: k1 and k2 in Q30.
    logic r2_v;
    logic signed [33:0] r2_k1, r2_k2;
    logic [2:0] r2_s;
    logic signed [MW-1:0] r2_m;
    logic signed [33:0] n_k2;
    logic signed [34:0] n_k1d;

    assign n_k2  = 34'(r1_k2p >>> 30);
    assign n_k1d = 35'(r1_cos) - 35'(n_k2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_k1 <= 34'(n_k1d >>> 1);
            r2_k2 <= n_k2;
            r2_s  <= r1_s;
            r2_m  <= r1_m;
        end
    end

    // Stage 3: scale by magnitude.
    logic r3_v;
    logic signed [PW-1:0] r3_p1, r3_p2;
    logic [2:0] r3_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
        if (i_en) begin
            r3_p1 <= PW'(r2_k1) * PW'(r2_m);
            r3_p2 <= PW'(r2_k2) * PW'(r2_m);
            r3_s  <= r2_s;
        end
    end

    // Stage 4: rounding to T1, T2 and the zero time.
    logic r4_v;
    logic signed [TW-1:0] r4_t1, r4_t2, r4_t0;
    logic [2:0] r4_s;
    logic signed [TW-1:0] n_t1, n_t2;

    assign n_t1 = TW'((r3_p1 + (PW'(1) <<< 29)) >>> 30);
    assign n_t2 = TW'((r3_p2 + (PW'(1) <<< 29)) >>> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
        if (i_en) begin
            r4_t1 <= n_t1;
            r4_t2 <= n_t2;
            r4_t0 <= TW'({1'b0, i_limit}) - n_t1 - n_t2;
            r4_s  <= r3_s;
        end
    end

    // Stage 5: sector mapping, halving and saturation.
    logic signed [TW+2:0] n_a2, n_b2, n_c2, w1, w2, w12, z0;

    function automatic logic signed [VOLT_BITS-1:0] sat(input logic signed [TW+2:0] v2);
        logic signed [TW+2:0] h;
        h = (v2 + (TW+3)'(1)) >>> 1;
        if (h > HI) return VOLT_BITS'(HI);
        if (h < LO) return VOLT_BITS'(LO);
        return VOLT_BITS'(h);
    endfunction

    always_comb begin
        z0  = (TW+3)'(r4_t0);
        w1  = ((TW+3)'(r4_t1) <<< 1) + z0;
        w2  = ((TW+3)'(r4_t2) <<< 1) + z0;
        w12 = (((TW+3)'(r4_t1) + (TW+3)'(r4_t2)) <<< 1) + z0;
        case (r4_s)
            3'd0: begin n_a2 = w12; n_b2 = w2;  n_c2 = z0;  end
            3'd1: begin n_a2 = w1;  n_b2 = w12; n_c2 = z0;  end
            3'd2: begin n_a2 = z0;  n_b2 = w12; n_c2 = w2;  end
            3'd3: begin n_a2 = z0;  n_b2 = w1;  n_c2 = w12; end
            3'd4: begin n_a2 = w2;  n_b2 = z0;  n_c2 = w12; end
            default: begin n_a2 = w12; n_b2 = z0; n_c2 = w1; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r4_v;
        end
        if (i_en) begin
            o_a      <= sat(n_a2);
            o_b      <= sat(n_b2);
            o_c      <= sat(n_c2);
            o_sector <= r4_s + 3'd1;
        end
    end

endmodule

// ===== test/tb.sv =====
module tb;
    import svpwm_pkg::*;

    typedef struct packed {
        logic signed [15:0] phase_a;
        logic signed [15:0] phase_b;
        logic signed [15:0] phase_c;
        logic [2:0]         sector;
    } phase_word_t;

    typedef struct {
        logic signed [15:0] volt_q;
        logic signed [15:0] volt_d;
        logic [15:0]        angle;
        bit                 typed;
        phase_word_t        want;
    } cmd_row_t;

    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  DRAIN_CYCLES   = 70;
    localparam int  RANDOM_PER_SET = 280;
    localparam longint INVK  = 64'sd652032874;
    localparam longint SQRT3 = 64'sd1859775393;
    localparam longint ATAN_TURN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [LIMIT_BITS-1:0]     i_cfg_data;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [15:0]        i_volt_q;
    logic signed [15:0]        i_volt_d;
    logic [15:0]               i_elec_angle;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [15:0]        o_phase_a;
    logic signed [15:0]        o_phase_b;
    logic signed [15:0]        o_phase_c;
    logic [2:0]                o_sector_num;

    phase_word_t       pending_phases[$];
    cmd_row_t          cmd_table[$];
    logic [14:0]       limit_copy;
    int                fail_count;
    int                quiet_cycles;
    bit                sender_idles;
    bit                receiver_idles;
    bit                hold_request;

    space_vector_pwm_duty u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_volt_q     (i_volt_q),
        .i_volt_d     (i_volt_d),
        .i_elec_angle (i_elec_angle),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_phase_a    (o_phase_a),
        .o_phase_b    (o_phase_b),
        .o_phase_c    (o_phase_c),
        .o_sector_num (o_sector_num)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Clamp a phase value to the signed 16-bit output range.
    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    // Fixed-point space-vector modulation of one q/d command.
    function automatic phase_word_t modulate(logic signed [15:0] q, logic signed [15:0] d,
                                             logic [15:0] ang, logic [14:0] lim);
        longint x, y, xn, mag, cx, cy, cz, k1, k2, t1, t2, t0, a2, b2, c2;
        bit [31:0] theta, offs, z, phi;
        bit [63:0] t6;
        int sidx;
        int i;
        phase_word_t r;
        theta = {ang, 16'h0000};
        if (d == 0) begin
            offs = QUARTER_TURN;
            mag = longint'(q);
        end else begin
            // Vectoring pass gives the offset angle and the magnitude.
            if (d < 0) begin
                x = -longint'(d) * 64;
                y = -longint'(q) * 64;
                z = HALF_TURN;
            end else begin
                x = longint'(d) * 64;
                y = longint'(q) * 64;
                z = 32'h0;
            end
            for (i = 0; i < 24; i++) begin
                if (y > 0) begin
                    xn = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + ATAN_TURN[i][31:0];
                end else begin
                    xn = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - ATAN_TURN[i][31:0];
                end
                x = xn;
            end
            offs = z;
            mag = (x * INVK + 64'sd34359738368) >>> 36;
        end
        theta = theta + offs;
        t6 = {32'h0, theta} * 64'd6;
        sidx = int'(t6[63:32]);
        phi = t6[31:0] / 32'd6;
        // Rotation pass gives sine and cosine of the angle within the sector.
        cx = INVK;
        cy = 0;
        cz = longint'({32'h0, phi});
        for (i = 0; i < 24; i++) begin
            if (cz >= 0) begin
                xn = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cz = cz - ATAN_TURN[i];
            end else begin
                xn = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cz = cz + ATAN_TURN[i];
            end
            cx = xn;
        end
        k2 = (SQRT3 * cy) >>> 30;
        k1 = (3 * cx - k2) >>> 1;
        t1 = (k1 * mag + 64'sd536870912) >>> 30;
        t2 = (k2 * mag + 64'sd536870912) >>> 30;
        t0 = longint'({49'h0, lim}) - t1 - t2;
        case (sidx)
            0: begin a2 = 2 * (t1 + t2) + t0; b2 = 2 * t2 + t0; c2 = t0; end
            1: begin a2 = 2 * t1 + t0; b2 = 2 * (t1 + t2) + t0; c2 = t0; end
            2: begin a2 = t0; b2 = 2 * (t1 + t2) + t0; c2 = 2 * t2 + t0; end
            3: begin a2 = t0; b2 = 2 * t1 + t0; c2 = 2 * (t1 + t2) + t0; end
            4: begin a2 = 2 * t2 + t0; b2 = t0; c2 = 2 * (t1 + t2) + t0; end
            default: begin a2 = 2 * (t1 + t2) + t0; b2 = t0; c2 = 2 * t1 + t0; end
        endcase
        r.phase_a = clamp16((a2 + 1) >>> 1);
        r.phase_b = clamp16((b2 + 1) >>> 1);
        r.phase_c = clamp16((c2 + 1) >>> 1);
        r.sector = 3'(sidx + 1);
        return r;
    endfunction

    // Offer one command word and hold it until the block takes it.
    task automatic send_command(cmd_row_t row);
        int gap;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_volt_q = row.volt_q;
        i_volt_d = row.volt_d;
        i_elec_angle = row.angle;
        do @(posedge i_clk); while (o_stall);
        pending_phases.push_back(row.typed ? row.want
                                 : modulate(row.volt_q, row.volt_d, row.angle, limit_copy));
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and let every outstanding word come out.
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_phases.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [14:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        limit_copy = value;
    endtask

    function automatic cmd_row_t random_command();
        cmd_row_t row;
        logic signed [15:0] corner [6] = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0,
                                           16'sd1, 16'sd32767};
        row.typed = 1'b0;
        row.want = '0;
        row.angle = 16'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                row.volt_q = 16'($urandom);
                row.volt_d = 16'sd0;
            end
            1: begin
                row.volt_q = corner[$urandom_range(0, 5)];
                row.volt_d = corner[$urandom_range(0, 5)];
            end
            2: begin
                row.volt_q = 16'($urandom_range(0, 128)) - 16'sd64;
                row.volt_d = 16'($urandom_range(0, 128)) - 16'sd64;
            end
            default: begin
                row.volt_q = 16'($urandom);
                row.volt_d = 16'($urandom);
            end
        endcase
        return row;
    endfunction

    task automatic add_row(logic signed [15:0] q, logic signed [15:0] d, logic [15:0] ang,
                           bit typed, phase_word_t want);
        cmd_row_t row;
        row.volt_q = q;
        row.volt_d = d;
        row.angle = ang;
        row.typed = typed;
        row.want = want;
        cmd_table.push_back(row);
    endtask

    // Output stall: short random bursts, or one long hold on request.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_stall = 1'b1;
                repeat (200) @(negedge i_clk);
                hold_request = 1'b0;
                i_stall = 1'b0;
            end else if (receiver_idles && $urandom_range(0, 6) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 3) - 1) @(negedge i_clk);
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // Compare each delivered word with the oldest prediction.
    always @(posedge i_clk) begin
        phase_word_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_phases.size() == 0) begin
                $error("unexpected output word");
                fail_count++;
            end else begin
                want = pending_phases.pop_front();
                if (o_phase_a !== want.phase_a) begin
                    $error("phase_a expected %0d got %0d", want.phase_a, o_phase_a);
                    fail_count++;
                end
                if (o_phase_b !== want.phase_b) begin
                    $error("phase_b expected %0d got %0d", want.phase_b, o_phase_b);
                    fail_count++;
                end
                if (o_phase_c !== want.phase_c) begin
                    $error("phase_c expected %0d got %0d", want.phase_c, o_phase_c);
                    fail_count++;
                end
                if (o_sector_num !== want.sector) begin
                    $error("sector_num expected %0d got %0d", want.sector, o_sector_num);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [14:0] limit_set [5] = '{15'd1, 15'd32767, 15'd1000, 15'd16384, 15'd0};
        int s;
        int n;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_volt_q = '0;
        i_volt_d = '0;
        i_elec_angle = '0;
        fail_count = 0;
        quiet_cycles = 0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        hold_request = 1'b0;
        limit_copy = LIMIT_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed commands; zero command at reset limit gives half limit on each phase.
        add_row(16'sd0, 16'sd0, 16'h0000, 1'b1, '{16'sd8192, 16'sd8192, 16'sd8192, 3'd2});
        add_row(16'sd0, 16'sd0, 16'h8000, 1'b1, '{16'sd8192, 16'sd8192, 16'sd8192, 3'd5});
        add_row(16'sd32767, 16'sd0, 16'h0000, 1'b0, '0);
        add_row(-16'sd32768, 16'sd0, 16'h1234, 1'b0, '0);
        add_row(16'sd0, 16'sd32767, 16'hFFFF, 1'b0, '0);
        add_row(16'sd0, -16'sd32768, 16'h4000, 1'b0, '0);
        add_row(-16'sd32768, -16'sd32768, 16'hC000, 1'b0, '0);
        add_row(16'sd32767, 16'sd32767, 16'h2AAA, 1'b0, '0);
        add_row(16'sd32767, -16'sd32768, 16'h2AAB, 1'b0, '0);
        add_row(16'sd1, 16'sd1, 16'h5555, 1'b0, '0);
        add_row(-16'sd1, -16'sd1, 16'h5556, 1'b0, '0);
        add_row(16'sd100, 16'sd1, 16'hAAAA, 1'b0, '0);
        add_row(16'sd0, 16'sd1, 16'hAAAB, 1'b0, '0);
        add_row(16'sd0, -16'sd1, 16'hD555, 1'b0, '0);
        add_row(16'sd20000, 16'sd0, 16'hD556, 1'b0, '0);
        add_row(-16'sd20000, 16'sd5, 16'h8000, 1'b0, '0);
        foreach (cmd_table[k]) send_command(cmd_table[k]);
        drain_pipeline();

        // Random phases, one per limit setting.
        for (s = 0; s < 5; s++) begin
            write_limit(limit_set[s]);
            if (s == 4) begin
                sender_idles = 1'b0;
                receiver_idles = 1'b0;
            end
            for (n = 0; n < RANDOM_PER_SET; n++) begin
                if (s == 1 && n == 20) hold_request = 1'b1;
                if (s == 2 && n == 100) drain_pipeline();
                send_command(random_command());
            end
            drain_pipeline();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_vec_cordic.sv
rtl/core/svpwm_rot_cordic.sv
rtl/core/svpwm_phase_map.sv
rtl/core/space_vector_pwm_duty.sv
test/tb.sv
